[rtl/core/mtrr_range_memory_type_resolver_defines.svh]
// ----------------------------------------------------------------------------
// MTRR resolver assertion macros
// Shared concurrent assertion forms used by the resolver RTL.
// ----------------------------------------------------------------------------
`ifndef MTRR_RANGE_MEMORY_TYPE_RESOLVER_DEFINES_SVH
`define MTRR_RANGE_MEMORY_TYPE_RESOLVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mrt_pkg.sv]
// ----------------------------------------------------------------------------
// MTRR resolver package
// Widths, memory type codes, stream field layout and shared types.
// ----------------------------------------------------------------------------
package mrt_pkg;

    localparam int PHYS_ADDR_BITS = 52;
    localparam int MAX_RANGES     = 16;
    localparam int FRAME_BITS     = 40;
    localparam int PAGE_BITS      = 18;
    localparam int TYPE_BITS      = 3;
    localparam int PAGE_SHIFT     = 12;
    localparam int LARGE_SHIFT    = 21;
    localparam int IDX_BITS       = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_BITS       = $clog2(MAX_RANGES + 1);

    // Input tdata layout, lowest field first.
    localparam int S_BASE_LSB  = 0;
    localparam int S_MASK_LSB  = S_BASE_LSB + FRAME_BITS;
    localparam int S_VALID_LSB = S_MASK_LSB + FRAME_BITS;
    localparam int S_TYPE_LSB  = S_VALID_LSB + 1;
    localparam int S_PAGE_LSB  = S_TYPE_LSB + TYPE_BITS;
    localparam int S_USED_BITS = S_PAGE_LSB + PAGE_BITS;
    localparam int S_DATA_BITS = ((S_USED_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest field first.
    localparam int M_TYPE_LSB  = 0;
    localparam int M_STORE_LSB = M_TYPE_LSB + TYPE_BITS;
    localparam int M_FULL_LSB  = M_STORE_LSB + 1;
    localparam int M_USED_BITS = M_FULL_LSB + 1;
    localparam int M_DATA_BITS = ((M_USED_BITS + 7) / 8) * 8;

    typedef logic [PHYS_ADDR_BITS-1:0] addr_t;
    typedef logic [TYPE_BITS-1:0]      mem_type_t;
    typedef logic [IDX_BITS-1:0]       idx_t;
    typedef logic [CNT_BITS-1:0]       cnt_t;
    typedef logic [PAGE_BITS-1:0]      page_t;

    localparam addr_t     ADDR_TOP = '1;
    localparam mem_type_t TYPE_UC  = 3'd0;
    localparam mem_type_t TYPE_WB  = 3'd6;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        addr_t     start;
        addr_t     last;
        mem_type_t kind;
    } range_entry_t;

    // Control from the sequencer to the overlap compare unit.
    typedef struct packed {
        logic  start;
        page_t frame;
        logic  entry_valid;
    } qry_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WRITE,
        ST_QUERY,
        ST_DONE
    } state_t;

endpackage

[rtl/core/mrt_range_mem.sv]
// ----------------------------------------------------------------------------
// MTRR range table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mrt_range_mem
    import mrt_pkg::*;
(
    input  logic         aclk,
    input  logic         wr_en,
    input  idx_t         wr_addr,
    input  range_entry_t wr_data,
    input  idx_t         rd_addr,
    output range_entry_t rd_data
);

    range_entry_t mem [MAX_RANGES];
    range_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/mrt_load_calc.sv]
// ----------------------------------------------------------------------------
// MTRR range end calculation
// Turns a base/mask frame pair into the start, last address and type of a range.
// ----------------------------------------------------------------------------
module mrt_load_calc
    import mrt_pkg::*;
(
    input  logic         aclk,
    input  logic         capture,
    input  logic [FRAME_BITS-1:0] base_frame,
    input  logic [FRAME_BITS-1:0] mask_frame,
    input  mem_type_t    range_type,
    output range_entry_t entry
);

    addr_t     base_addr;
    addr_t     mask_addr;
    addr_t     span;
    addr_t     base_reg;
    addr_t     span_reg;
    logic      mask_zero_reg;
    mem_type_t type_reg;
    logic [PHYS_ADDR_BITS:0] sum;

    assign base_addr = addr_t'({base_frame, {PAGE_SHIFT{1'b0}}});
    assign mask_addr = addr_t'({mask_frame, {PAGE_SHIFT{1'b0}}});

    // Bits below the lowest set bit of the mask: size minus one.
    assign span = (mask_addr - addr_t'(1)) & ~mask_addr;

    always_ff @(posedge aclk) begin
        if (capture) begin
            base_reg      <= base_addr;
            span_reg      <= span;
            mask_zero_reg <= (mask_addr == '0);
            type_reg      <= range_type;
        end
    end

    // A carry out of the add means the range runs past the top address.
    assign sum = {1'b0, base_reg} + {1'b0, span_reg};

    always_comb begin
        entry.start = base_reg;
        entry.kind  = type_reg;
        if (mask_zero_reg || sum[PHYS_ADDR_BITS]) begin
            entry.last = ADDR_TOP;
        end else begin
            entry.last = sum[PHYS_ADDR_BITS-1:0];
        end
    end

endmodule

[rtl/core/mrt_query_cmp.sv]
// ----------------------------------------------------------------------------
// MTRR page overlap compare
// Checks each streamed table entry against the queried 2 MB page.
// ----------------------------------------------------------------------------
module mrt_query_cmp
    import mrt_pkg::*;
(
    input  logic         aclk,
    input  qry_ctl_t     ctl,
    input  range_entry_t rd_entry,
    output mem_type_t    memory_type
);

    page_t     frame_reg;
    logic      uc_reg;
    mem_type_t type_reg;
    addr_t     page_first;
    addr_t     page_end;
    logic      overlap;

    assign page_first = addr_t'({frame_reg, {LARGE_SHIFT{1'b0}}});
    assign page_end   = addr_t'({frame_reg, {LARGE_SHIFT{1'b1}}});
    assign overlap    = (page_first <= rd_entry.last) && (page_end >= rd_entry.start);

    // Page frame zero and any uncacheable hit are sticky; otherwise the last hit sets the type.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            frame_reg <= ctl.frame;
            uc_reg    <= (ctl.frame == '0);
            type_reg  <= TYPE_WB;
        end else if (ctl.entry_valid && overlap) begin
            type_reg <= rd_entry.kind;
            if (rd_entry.kind == TYPE_UC) begin
                uc_reg <= 1'b1;
            end
        end
    end

    assign memory_type = uc_reg ? TYPE_UC : type_reg;

endmodule

[rtl/core/mtrr_range_memory_type_resolver.sv]
// ----------------------------------------------------------------------------
// MTRR variable-range memory type resolver
// Stores variable memory-type ranges and classifies 2 MB pages against them.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A load that stores a range passes through
// a write state before its result. For a query the table sits in a memory
// with one read port, and one entry is read and compared per cycle. The
// result sits in an output register, so the next item is taken while it
// waits for the downstream side. The table needs no clearing after reset;
// only entries below the stored count are ever read.
`include "mtrr_range_memory_type_resolver_defines.svh"

module mtrr_range_memory_type_resolver
    import mrt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // base_frame[39:0], mask_frame[79:40], range_valid[80], range_type[83:81],
    // page_frame[101:84], zero padding above
    input  logic [S_DATA_BITS-1:0] s_tdata,
    // kind[0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // memory_type[2:0], range_stored[3], table_full[4], zero padding above
    output logic [M_DATA_BITS-1:0] m_tdata
);

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    cnt_t   issue_reg, issue_next;
    logic   cmp_valid_reg, cmp_valid_next;
    logic   is_query_reg, is_query_next;
    logic   stored_reg, stored_next;
    logic   full_reg, full_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic [FRAME_BITS-1:0] in_base;
    logic [FRAME_BITS-1:0] in_mask;
    logic                  in_valid;
    mem_type_t             in_type;
    page_t                 in_page;

    logic         s_xfer;
    logic         out_free;
    logic         storable;
    logic         table_has_room;
    logic         issue_more;
    logic         mem_we;
    range_entry_t load_entry;
    range_entry_t rd_entry;
    qry_ctl_t     qctl;
    mem_type_t    query_type;

    assign in_base  = s_tdata[S_BASE_LSB +: FRAME_BITS];
    assign in_mask  = s_tdata[S_MASK_LSB +: FRAME_BITS];
    assign in_valid = s_tdata[S_VALID_LSB];
    assign in_type  = s_tdata[S_TYPE_LSB +: TYPE_BITS];
    assign in_page  = s_tdata[S_PAGE_LSB +: PAGE_BITS];

    assign s_tready       = (state_reg == ST_IDLE);
    assign s_xfer         = s_tvalid && s_tready;
    assign out_free       = !m_tvalid_reg || m_tready;
    assign storable       = in_valid && (in_type != TYPE_WB);
    assign table_has_room = (count_reg < cnt_t'(MAX_RANGES));
    assign issue_more     = (issue_reg < count_reg);

    mrt_load_calc u_load_calc (
        .aclk       (aclk),
        .capture    (s_xfer),
        .base_frame (in_base),
        .mask_frame (in_mask),
        .range_type (in_type),
        .entry      (load_entry)
    );

    mrt_range_mem u_range_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[IDX_BITS-1:0]),
        .wr_data (load_entry),
        .rd_addr (issue_reg[IDX_BITS-1:0]),
        .rd_data (rd_entry)
    );

    mrt_query_cmp u_query_cmp (
        .aclk        (aclk),
        .ctl         (qctl),
        .rd_entry    (rd_entry),
        .memory_type (query_type)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == KIND_QUERY) begin
                        state_next = ST_QUERY;
                    end else if (storable && table_has_room) begin
                        state_next = ST_LOAD_WRITE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOAD_WRITE: begin
                state_next = ST_DONE;
            end
            ST_QUERY: begin
                if (!issue_more && !cmp_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        is_query_next  = is_query_reg;
        stored_next    = stored_reg;
        full_next      = full_reg;
        mem_we         = 1'b0;
        qctl.start       = 1'b0;
        qctl.frame       = in_page;
        qctl.entry_valid = cmp_valid_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    is_query_next = (s_tuser == KIND_QUERY);
                    stored_next   = 1'b0;
                    full_next     = (s_tuser == KIND_LOAD) && storable && !table_has_room;
                    issue_next    = '0;
                    qctl.start    = (s_tuser == KIND_QUERY);
                end
            end
            ST_LOAD_WRITE: begin
                mem_we      = 1'b1;
                count_next  = count_reg + cnt_t'(1);
                stored_next = 1'b1;
            end
            ST_QUERY: begin
                if (issue_more) begin
                    issue_next     = issue_reg + cnt_t'(1);
                    cmp_valid_next = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[M_TYPE_LSB +: TYPE_BITS] =
                        is_query_reg ? query_type : TYPE_UC;
                    m_tdata_next[M_STORE_LSB] = stored_reg;
                    m_tdata_next[M_FULL_LSB]  = full_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg    <= issue_next;
        is_query_reg <= is_query_next;
        stored_reg   <= stored_next;
        full_reg     <= full_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `MRT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= cnt_t'(MAX_RANGES),
        "range count exceeds table size")
    `MRT_ASSERT_NOW(a_write_room, mem_we, table_has_room,
        "range written into a full table")
    `MRT_ASSERT_NEXT(a_count_step, mem_we, count_reg == $past(count_reg) + cnt_t'(1),
        "range count did not advance after a write")
    `MRT_ASSERT_NOW(a_idle_no_scan, s_tready, !cmp_valid_reg,
        "new item accepted while a compare is pending")

endmodule
